// ===== hdl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the per-barcode read gap clusterer.
// ----------------------------------------------------------------------------
package bgc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;
    localparam logic [1:0] CFG_CHROM_ID   = 2'd2;

    // configuration reset values
    localparam logic [30:0] GAP_LIMIT_DEFAULT  = 31'd50000;
    localparam logic [30:0] MIN_LENGTH_DEFAULT = 31'd1000;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic bc_ok;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== hdl/per_barcode_read_gap_clusterer.sv =====
// ----------------------------------------------------------------------------
// per_barcode_read_gap_clusterer
// Groups position-sorted reads into molecules, one open molecule per barcode.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  --------  -------------------------------------------  ---------
//  input     in_valid/in_ready, func barcode pos          in
//            read_length
//  output    out_valid/out_ready, out_barcode out_chrom   out
//            mol_start mol_end mol_length read_count
//  config    cfg_we cfg_index cfg_data (write only)       in
//
//  each request makes a single read-modify-write pass through the barcode table
//  (table read, gap test, table write-back)
//  after reset a clearing pass over every table entry runs, in_ready low
//  the write-back waits while a previous result is still held at the output
//  a barcode at or above NUM_BARCODES is accepted and dropped
// ----------------------------------------------------------------------------
module per_barcode_read_gap_clusterer
#(
    parameter int NUM_BARCODES = 4096,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [11:0] barcode,
    input  logic [30:0] pos,
    input  logic [15:0] read_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] out_barcode,
    output logic [15:0] out_chrom,
    output logic [30:0] mol_start,
    output logic [31:0] mol_end,
    output logic [31:0] mol_length,
    output logic [15:0] read_count
);

    bgc_pkg::ctrl_cmd_t    cmd;
    bgc_pkg::ctrl_status_t status;

    bgc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bgc_datapath
    #(
        .NUM_BARCODES (NUM_BARCODES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .barcode     (barcode),
        .pos         (pos),
        .read_length (read_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_barcode (out_barcode),
        .out_chrom   (out_chrom),
        .mol_start   (mol_start),
        .mol_end     (mol_end),
        .mol_length  (mol_length),
        .read_count  (read_count)
    );

    // a new result only appears from a write-back
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result appeared without a write-back");

    // write-back never overwrites a result still waiting
    a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("write-back while output held");

    // an in-range request blocks the input until its write-back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.bc_ok) |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a request is in flight");

    // no table write from a request during the clearing pass
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> (!cmd.commit && !in_ready))
        else $error("request handled during clearing pass");

endmodule

// ===== hdl/bgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgc_ctrl
// Sequencer: table clearing pass, then read, evaluate and commit per request.
// ----------------------------------------------------------------------------
module bgc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bgc_pkg::ctrl_status_t status,
    output bgc_pkg::ctrl_cmd_t    cmd
);

    bgc_pkg::state_t state_reg;
    bgc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bgc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgc_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = bgc_pkg::ST_IDLE;
                end
            end
            bgc_pkg::ST_IDLE:
            begin
                // out-of-range barcodes are dropped at accept
                if (in_valid && status.bc_ok)
                begin
                    state_next = bgc_pkg::ST_LOOKUP;
                end
            end
            bgc_pkg::ST_LOOKUP:
            begin
                state_next = bgc_pkg::ST_COMMIT;
            end
            bgc_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = bgc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.lookup     = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            bgc_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            bgc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            bgc_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            bgc_pkg::ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/bgc_datapath.sv =====
// ----------------------------------------------------------------------------
// bgc_datapath
// Barcode table memory, configuration registers, gap and span arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module bgc_datapath
#(
    parameter int NUM_BARCODES = 4096,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgc_pkg::ctrl_cmd_t    cmd,
    output bgc_pkg::ctrl_status_t status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic                  func,
    input  logic [11:0]           barcode,
    input  logic [30:0]           pos,
    input  logic [15:0]           read_length,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [11:0]           out_barcode,
    output logic [15:0]           out_chrom,
    output logic [30:0]           mol_start,
    output logic [31:0]           mol_end,
    output logic [31:0]           mol_length,
    output logic [15:0]           read_count
);

    localparam int AW     = (NUM_BARCODES > 1) ? $clog2(NUM_BARCODES) : 1;
    localparam int WORD_W = 1 + 31 + 31 + 16 + COUNT_WIDTH;
    // word layout from the top: used, first, last, length, count
    localparam int CNT_LO   = 0;
    localparam int LEN_LO   = COUNT_WIDTH;
    localparam int LAST_LO  = COUNT_WIDTH + 16;
    localparam int FIRST_LO = COUNT_WIDTH + 47;
    localparam int USED_BIT = COUNT_WIDTH + 78;

    // configuration
    logic [30:0] gap_limit_reg;
    logic [30:0] min_length_reg;
    logic [15:0] chrom_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= bgc_pkg::GAP_LIMIT_DEFAULT;
            min_length_reg <= bgc_pkg::MIN_LENGTH_DEFAULT;
            chrom_id_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bgc_pkg::CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_data;
                bgc_pkg::CFG_MIN_LENGTH: min_length_reg <= cfg_data;
                bgc_pkg::CFG_CHROM_ID:   chrom_id_reg   <= cfg_data[15:0];
                default:                 chrom_id_reg   <= chrom_id_reg;
            endcase
        end
    end

    // clearing pass over the table
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // input address and range check
    logic [31:0]   bc_wide;
    logic [AW-1:0] in_addr;

    assign bc_wide = 32'(barcode);
    assign in_addr = bc_wide[AW-1:0];

    assign status.bc_ok      = (bc_wide < 32'(NUM_BARCODES));
    assign status.clear_done = (clr_addr_reg == AW'(NUM_BARCODES - 1));
    assign status.out_free   = !out_valid || out_ready;

    // item capture
    logic          func_reg;
    logic [11:0]   bc_reg;
    logic [AW-1:0] addr_reg;
    logic [30:0]   pos_reg;
    logic [15:0]   len_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            bc_reg   <= barcode;
            addr_reg <= in_addr;
            pos_reg  <= pos;
            len_reg  <= read_length;
        end
    end

    // table memory
    logic [WORD_W-1:0] mem [NUM_BARCODES];
    logic [WORD_W-1:0] rd_word_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_word_reg <= mem[in_addr];
        end
    end

    logic                   rd_used;
    logic [30:0]            rd_first;
    logic [30:0]            rd_last;
    logic [15:0]            rd_len;
    logic [COUNT_WIDTH-1:0] rd_cnt;

    assign rd_used  = rd_word_reg[USED_BIT];
    assign rd_first = rd_word_reg[FIRST_LO +: 31];
    assign rd_last  = rd_word_reg[LAST_LO +: 31];
    assign rd_len   = rd_word_reg[LEN_LO +: 16];
    assign rd_cnt   = rd_word_reg[CNT_LO +: COUNT_WIDTH];

    // lookup stage: gap test and molecule end
    logic [31:0] gap_sum;
    logic        gap_close_reg;
    logic [31:0] end_reg;

    assign gap_sum = {1'b0, rd_last} + {1'b0, gap_limit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            gap_close_reg <= ({1'b0, pos_reg} > gap_sum);
            end_reg       <= {1'b0, rd_last} + 32'(rd_len);
        end
    end

    // commit stage: span check, table update, result
    logic [32:0]            span_wide;
    logic                   span_ok;
    logic                   close_mol;
    logic                   emit;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [WORD_W-1:0]      new_word;

    assign span_wide = {1'b0, end_reg} - {2'b00, rd_first};
    // a negative span (unsorted reads) is never reported
    assign span_ok   = !span_wide[32] && (span_wide[31:0] >= {1'b0, min_length_reg});
    assign close_mol = rd_used && ((func_reg == bgc_pkg::FUNC_FLUSH) || gap_close_reg);
    assign emit      = close_mol && span_ok;
    assign cnt_inc   = (rd_cnt == {COUNT_WIDTH{1'b1}}) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);

    always_comb
    begin
        if (func_reg == bgc_pkg::FUNC_FLUSH)
        begin
            new_word = '0;
        end
        else if (!rd_used || gap_close_reg)
        begin
            new_word = {1'b1, pos_reg, pos_reg, len_reg, COUNT_WIDTH'(1)};
        end
        else
        begin
            new_word = {1'b1, rd_first, pos_reg, len_reg, cnt_inc};
        end
    end

    assign wr_en   = cmd.clear_step || cmd.commit;
    assign wr_addr = cmd.clear_step ? clr_addr_reg : addr_reg;
    assign wr_word = cmd.clear_step ? '0 : new_word;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [11:0] out_barcode_reg;
    logic [15:0] out_chrom_reg;
    logic [30:0] mol_start_reg;
    logic [31:0] mol_end_reg;
    logic [31:0] mol_length_reg;
    logic [31:0] cnt_wide;
    logic [15:0] read_count_reg;

    assign cnt_wide = 32'(rd_cnt);

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            out_barcode_reg <= bc_reg;
            out_chrom_reg   <= chrom_id_reg;
            mol_start_reg   <= rd_first;
            mol_end_reg     <= end_reg;
            mol_length_reg  <= span_wide[31:0];
            read_count_reg  <= cnt_wide[15:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_barcode = out_barcode_reg;
    assign out_chrom   = out_chrom_reg;
    assign mol_start   = mol_start_reg;
    assign mol_end     = mol_end_reg;
    assign mol_length  = mol_length_reg;
    assign read_count  = read_count_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-barcode read gap clusterer.
// Feeds directed and random read/flush requests through the input channel,
// predicts every emitted molecule from a per-barcode table kept in the bench,
// and compares each output molecule field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_BC      = 4096;
    localparam int LONG_HOLD   = 300;
    localparam int SAT_READS   = 20;

    typedef struct {
        logic        func;
        logic [11:0] barcode;
        logic [30:0] pos;
        logic [15:0] len;
    } read_req_t;

    typedef struct {
        logic [11:0] bc;
        logic [15:0] chrom;
        logic [30:0] first_pos;
        logic [31:0] end_pos;
        logic [31:0] span;
        logic [15:0] reads;
    } molecule_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = bgc_pkg::CFG_GAP_LIMIT;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = bgc_pkg::FUNC_ADD;
    logic [11:0] barcode = '0;
    logic [30:0] pos = '0;
    logic [15:0] read_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] out_barcode;
    logic [15:0] out_chrom;
    logic [30:0] mol_start;
    logic [31:0] mol_end;
    logic [31:0] mol_length;
    logic [15:0] read_count;

    // requests waiting for the driver, molecules waiting for the output
    read_req_t read_feed_q[$];
    molecule_t molecule_q[$];

    // bench copy of the barcode table and registers
    bit          used_tab  [NUM_BC];
    logic [30:0] first_tab [NUM_BC];
    logic [30:0] last_tab  [NUM_BC];
    logic [15:0] len_tab   [NUM_BC];
    logic [15:0] count_tab [NUM_BC];
    logic [30:0] gap_now   = bgc_pkg::GAP_LIMIT_DEFAULT;
    logic [30:0] min_now   = bgc_pkg::MIN_LENGTH_DEFAULT;
    logic [15:0] chrom_now = '0;

    int  errors = 0;
    int  n_offered = 0;
    int  n_accepted = 0;
    int  cycles = 0;
    bit  in_fire = 1'b0;
    bit  calm = 1'b0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  send_gap = 0;
    int  take_gap = 0;

    per_barcode_read_gap_clusterer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .barcode     (barcode),
        .pos         (pos),
        .read_length (read_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_barcode (out_barcode),
        .out_chrom   (out_chrom),
        .mol_start   (mol_start),
        .mol_end     (mol_end),
        .mol_length  (mol_length),
        .read_count  (read_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    task automatic seal_molecule(input logic [11:0] bc);
        molecule_t   m;
        logic [31:0] e;
        e = {1'b0, last_tab[bc]} + {16'd0, len_tab[bc]};
        // unsorted input can put the end below the start
        if (e >= {1'b0, first_tab[bc]} && e - {1'b0, first_tab[bc]} >= {1'b0, min_now})
        begin
            m.bc        = bc;
            m.chrom     = chrom_now;
            m.first_pos = first_tab[bc];
            m.end_pos   = e;
            m.span      = e - {1'b0, first_tab[bc]};
            m.reads     = count_tab[bc];
            molecule_q.push_back(m);
        end
    endtask

    task automatic seed_molecule(input logic [11:0] bc, input logic [30:0] p,
                                 input logic [15:0] len);
        used_tab[bc]  = 1'b1;
        first_tab[bc] = p;
        last_tab[bc]  = p;
        len_tab[bc]   = len;
        count_tab[bc] = 16'd1;
    endtask

    task automatic cluster_read(input logic f, input logic [11:0] bc, input logic [30:0] p,
                                input logic [15:0] len);
        if (f == bgc_pkg::FUNC_FLUSH)
        begin
            if (used_tab[bc])
                seal_molecule(bc);
            used_tab[bc] = 1'b0;
        end
        else if (!used_tab[bc])
            seed_molecule(bc, p, len);
        else if ({1'b0, p} > {1'b0, last_tab[bc]} + {1'b0, gap_now})
        begin
            seal_molecule(bc);
            seed_molecule(bc, p, len);
        end
        else
        begin
            last_tab[bc] = p;
            len_tab[bc]  = len;
            if (count_tab[bc] != 16'hFFFF)
                count_tab[bc] = count_tab[bc] + 16'd1;
        end
    endtask

    function automatic void cmp(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        read_req_t req;
        if (!(in_valid && !in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (read_feed_q.size() > 0)
            begin
                req = read_feed_q.pop_front();
                func        <= req.func;
                barcode     <= req.barcode;
                pos         <= req.pos;
                read_length <= req.len;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            take_gap = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            take_gap = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        molecule_t m;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            n_accepted++;
            cluster_read(func, barcode, pos, read_length);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (molecule_q.size() == 0)
            begin
                $display("%0t: unexpected molecule bc %0h start %0h end %0h count %0d",
                         $time, out_barcode, mol_start, mol_end, read_count);
                errors++;
            end
            else
            begin
                m = molecule_q.pop_front();
                cmp("out_barcode", 32'(m.bc), 32'(out_barcode));
                cmp("out_chrom", 32'(m.chrom), 32'(out_chrom));
                cmp("mol_start", 32'(m.first_pos), 32'(mol_start));
                cmp("mol_end", m.end_pos, mol_end);
                cmp("mol_length", m.span, mol_length);
                cmp("read_count", 32'(m.reads), 32'(read_count));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL per_barcode_read_gap_clusterer");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic offer_read(input logic f, input logic [11:0] bc, input logic [30:0] p,
                              input logic [15:0] len);
        read_req_t r;
        r.func    = f;
        r.barcode = bc;
        r.pos     = p;
        r.len     = len;
        read_feed_q.push_back(r);
        n_offered++;
    endtask

    // block idle: every request taken, every molecule out, pipeline empty
    task automatic settle();
        while (n_accepted != n_offered || molecule_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            bgc_pkg::CFG_GAP_LIMIT:  gap_now = val;
            bgc_pkg::CFG_MIN_LENGTH: min_now = val;
            bgc_pkg::CFG_CHROM_ID:   chrom_now = val[15:0];
            default: ;
        endcase
    endtask

    // mostly position-sorted reads over a small barcode pool, plus flushes and noise
    task automatic random_reads(input int count, input int pool, input int unsigned step_max,
                                input int unsigned len_max);
        logic [30:0]     cur [64];
        logic [11:0]     bc_mask;
        longint unsigned c;
        int              r;
        int              k;
        bc_mask = 12'($urandom);
        for (int i = 0; i < 64; i++)
            cur[i] = 31'($urandom_range(0, 1000000));
        @(posedge clk);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, pool - 1);
            if (r < 7)
                offer_read(bgc_pkg::FUNC_FLUSH, k[11:0] ^ bc_mask, 31'($urandom),
                           16'($urandom));
            else if (r < 17)
                offer_read($urandom_range(0, 4) == 0 ? bgc_pkg::FUNC_FLUSH : bgc_pkg::FUNC_ADD,
                           12'($urandom), 31'($urandom), 16'($urandom));
            else
            begin
                c = longint'(cur[k]) + $urandom_range(0, step_max);
                if (c > 64'h7FFF_FFFF)
                    c = 64'($urandom_range(0, 1000));
                cur[k] = c[30:0];
                offer_read(bgc_pkg::FUNC_ADD, k[11:0] ^ bc_mask, cur[k],
                           16'($urandom_range(0, len_max)));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values: gap 50000, min length 1000
        @(posedge clk);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h000, 31'h7FFFFFFF, 16'hFFFF);   // empty entry
        offer_read(bgc_pkg::FUNC_ADD, 12'h000, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h000, 31'd50000, 16'd100);     // gap exactly at limit
        offer_read(bgc_pkg::FUNC_ADD, 12'h000, 31'd100001, 16'hFFFF);   // one past the limit
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h000, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h000, 31'd7, 16'd3);           // reuse after flush
        offer_read(bgc_pkg::FUNC_ADD, 12'hFFF, 31'h7FFFFFFF, 16'hFFFF);
        offer_read(bgc_pkg::FUNC_ADD, 12'hFFF, 31'h7FFFFFFF, 16'd0);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'hFFF, 31'd0, 16'd0);         // span too short
        offer_read(bgc_pkg::FUNC_ADD, 12'h005, 31'd10000, 16'd10);
        offer_read(bgc_pkg::FUNC_ADD, 12'h005, 31'd100, 16'd10);        // end below start
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h005, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h006, 31'd2000, 16'd1000);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h006, 31'd0, 16'd0);         // span equals minimum
        offer_read(bgc_pkg::FUNC_ADD, 12'h006, 31'd2000, 16'd999);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h006, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'hAAA, 31'h2AAAAAAA, 16'hAAAA);
        offer_read(bgc_pkg::FUNC_ADD, 12'hAAA, 31'h2AAAAAAB, 16'h5555); // back to back
        offer_read(bgc_pkg::FUNC_ADD, 12'hAAA, 31'h2AAAAAAC, 16'h1234);
        offer_read(bgc_pkg::FUNC_ADD, 12'h555, 31'h55555555, 16'h5555);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'hAAA, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h555, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h000, 31'd0, 16'd0);
        settle();

        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'd1000);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'd500);
        write_reg(bgc_pkg::CFG_CHROM_ID, 31'($urandom));
        random_reads(400, 48, 1300, 2000);
        settle();

        // low extremes: any forward step closes, every non-negative span is reported
        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'd0);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'd0);
        write_reg(bgc_pkg::CFG_CHROM_ID, 31'd0);
        @(posedge clk);
        offer_read(bgc_pkg::FUNC_ADD, 12'h3C0, 31'd7, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h3C0, 31'd7, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h3C0, 31'd8, 16'd0);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h3C0, 31'd0, 16'd0);
        random_reads(300, 32, 3, 4);
        settle();

        // high extremes: nothing closes on a gap, only a span of at least 7FFFFFFF is reported
        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'h7FFFFFFF);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'h7FFFFFFF);
        write_reg(bgc_pkg::CFG_CHROM_ID, 31'h0000FFFF);
        @(posedge clk);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h001, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h001, 31'd0, 16'd0);
        offer_read(bgc_pkg::FUNC_ADD, 12'h001, 31'h7FFFFFFF, 16'hFFFF);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'h001, 31'd0, 16'd0);
        random_reads(250, 32, 32'h3FFF_FFFF, 65535);
        settle();

        // long run of close reads on one barcode
        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'd100);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'd10);
        write_reg(bgc_pkg::CFG_CHROM_ID, 31'h1234);
        @(posedge clk);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'hABC, 31'd0, 16'd0);
        for (int i = 0; i < SAT_READS; i++)
            offer_read(bgc_pkg::FUNC_ADD, 12'hABC, 31'(1000 + i), 16'd10);
        offer_read(bgc_pkg::FUNC_FLUSH, 12'hABC, 31'd0, 16'd0);
        settle();

        // output held off while closing requests keep coming
        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'd1000);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'd500);
        @(posedge clk);
        hold_asked++;
        for (int i = 0; i < 16; i++)
        begin
            offer_read(bgc_pkg::FUNC_ADD, 12'(12'h800 + i), 31'd20000, 16'd1000);
            offer_read(bgc_pkg::FUNC_ADD, 12'(12'h800 + i), 31'd25000, 16'd1000);
        end
        random_reads(300, 48, 1300, 2000);
        settle();

        write_reg(bgc_pkg::CFG_GAP_LIMIT, 31'd20000);
        write_reg(bgc_pkg::CFG_MIN_LENGTH, 31'd2000);
        write_reg(bgc_pkg::CFG_CHROM_ID, 31'($urandom));
        random_reads(250, 64, 26000, 65535);
        calm = 1'b1;
        random_reads(200, 64, 26000, 65535);

        while (n_accepted != n_offered || molecule_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("PASS per_barcode_read_gap_clusterer");
        else
            $display("FAIL per_barcode_read_gap_clusterer");
        $finish;
    end

endmodule
